/* hw/rtl/tcfp_pkg.sv */
// Shared types and constants of the tuning command frame parser.
package tcfp_pkg;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  loop_select;
		logic [1:0]  gain_select;
		logic [31:0] gain_value;
	} out_beat_t;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FRAMING = 2'd1;
	localparam logic [1:0] ST_LETTER  = 2'd2;
	localparam logic [1:0] ST_UNSUP   = 2'd3;

	// Classified frame command handed from the front to the back part.
	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  loop_select;
		logic [1:0]  gain_select;
		op_t         op;
		logic [2:0]  slot;
		logic [31:0] payload;
	} cmd_t;

	localparam logic [7:0] CH_AT   = 8'h40;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_3    = 8'h33;

	localparam int unsigned MIN_FRAME = 11;
	localparam logic [31:0] CANON_NAN = 32'h7FC00000;

endpackage

/* hw/rtl/tuning_command_frame_parser_core.sv */
// Top level of the tuning command frame parser.
// A frame's status beat is registered in the queue and then in the back part's result
// register; an add or subtract also passes the first stage of the two-stage float adder.
// Throughput: one input beat per cycle while the queue is not full; the back part takes
// the next frame command only after its last status beat is taken, a two-entry queue absorbs bursts.
// Reset clears frame state, the queue and all six gains to +0.0.
module tuning_command_frame_parser_core import tcfp_pkg::*; #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	logic cmd_valid, q_full, q_valid, q_pop;
	cmd_t cmd, q_cmd;
	logic in_fire;

	// Stall input only when the queue cannot take a frame end.
	assign in_stall = q_full;
	assign in_fire  = in_valid && !in_stall;

	tcfp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data), .in_fire(in_fire),
		.cmd_valid(cmd_valid), .cmd(cmd)
	);

	tcfp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(cmd_valid), .din(cmd), .full(q_full),
		.pop_valid(q_valid), .dout(q_cmd), .pop(q_pop)
	);

	tcfp_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_valid), .cmd(q_cmd),
		.cmd_take(q_pop), .res_valid(out_valid), .res(out_data),
		.res_take(!out_stall)
	);

endmodule

/* hw/rtl/tcfp_front.sv */
// Front part: collects frame bytes and classifies a frame at its last byte.
module tcfp_front import tcfp_pkg::*; #(
	parameter int unsigned MAX_FRAME = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_beat_t in_beat,
	input  logic     in_fire,
	output logic     cmd_valid,
	output cmd_t     cmd
);

	logic [6:0]  pos_q;
	logic [7:0]  hdr_q [5];
	logic [31:0] pay_q;
	logic [7:0]  prev_q;
	logic        over_q;

	logic [7:0]  b;
	logic [7:0]  h0, h1, h2, h3, h4;
	logic [31:0] pay;
	logic [1:0]  lp, gn;
	logic        lp_ok, gn_ok, op_ok;
	op_t         op;
	logic [7:0]  len;

	assign b = in_beat.rx_byte;

	// Bytes as they stand with the current beat written in.
	always_comb begin
		h0 = (pos_q == 7'd0) ? b : hdr_q[0];
		h1 = (pos_q == 7'd1) ? b : hdr_q[1];
		h2 = (pos_q == 7'd2) ? b : hdr_q[2];
		h3 = (pos_q == 7'd3) ? b : hdr_q[3];
		h4 = (pos_q == 7'd4) ? b : hdr_q[4];
		pay = pay_q;
		if (pos_q == 7'd5) pay[7:0]   = b;
		if (pos_q == 7'd6) pay[15:8]  = b;
		if (pos_q == 7'd7) pay[23:16] = b;
		if (pos_q == 7'd8) pay[31:24] = b;
		len = {1'b0, pos_q} + 8'd1;
	end

	always_comb begin
		lp = 2'd0; lp_ok = 1'b1;
		case (h1)
			CH_B: lp = 2'd0;
			CH_S: lp = 2'd1;
			CH_T: lp = 2'd2;
			default: lp_ok = 1'b0;
		endcase
		gn = 2'd0; gn_ok = 1'b1;
		case (h3)
			CH_P: gn = 2'd0;
			CH_I: gn = 2'd1;
			CH_D: gn = 2'd2;
			default: gn_ok = 1'b0;
		endcase
		op = OP_SET; op_ok = 1'b1;
		case (h2)
			CH_1: op = OP_SET;
			CH_2: op = OP_ADD;
			CH_3: op = OP_SUB;
			default: op_ok = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = op;
		cmd.payload = pay;
		cmd.slot = {lp, 1'b0} + {2'b00, (gn != 2'd0)};
		if (over_q || (pos_q >= 7'(MAX_FRAME)) || len < 8'(MIN_FRAME) ||
		    len > 8'(MAX_FRAME) || h0 != CH_AT || h4 != CH_EQ ||
		    prev_q != CH_BANG || b != CH_HASH) begin
			cmd.status = ST_FRAMING;
			cmd.payload = '0;
		end else if (!(lp_ok && gn_ok && op_ok)) begin
			cmd.status = ST_LETTER;
			cmd.loop_select = lp;
			cmd.gain_select = gn;
		end else begin
			cmd.loop_select = lp;
			cmd.gain_select = gn;
			if ((gn == 2'd1 && lp != 2'd1) || (gn == 2'd2 && lp == 2'd1))
				cmd.status = ST_UNSUP;
			else
				cmd.status = ST_OK;
		end
	end

	assign cmd_valid = in_fire && in_beat.frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			prev_q <= '0;
			over_q <= 1'b0;
			pay_q  <= '0;
			for (int i = 0; i < 5; i++) hdr_q[i] <= '0;
		end else if (in_fire) begin
			if (in_beat.frame_end) begin
				pos_q  <= '0;
				prev_q <= '0;
				over_q <= 1'b0;
				pay_q  <= '0;
				for (int i = 0; i < 5; i++) hdr_q[i] <= '0;
			end else begin
				hdr_q[0] <= h0; hdr_q[1] <= h1; hdr_q[2] <= h2;
				hdr_q[3] <= h3; hdr_q[4] <= h4;
				pay_q  <= pay;
				prev_q <= b;
				if (pos_q >= 7'(MAX_FRAME)) over_q <= 1'b1;
				else pos_q <= pos_q + 7'd1;
			end
		end
	end

endmodule

/* hw/rtl/tcfp_fadd.sv */
// Two-stage single-precision adder, round to nearest even, canonical NaN.
module tcfp_fadd (
	input  logic        clk,
	input  logic        go,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum
);

	// Stage 1: unpack, order operands and align.
	logic        sa, sb, big_s;
	logic [7:0]  ea, eb, big_e;
	logic [23:0] ma, mb, mbig, msml;
	logic [7:0]  d;
	logic [26:0] sml_al;
	logic        sticky;
	logic        swap;
	logic        a_nan, b_nan, a_inf, b_inf;

	logic        sub_s1, big_s_s1, special_s1;
	logic [31:0] special_v_s1;
	logic [7:0]  e_s1;
	logic [26:0] mbig_s1, msml_s1;

	always_comb begin
		sa = a[31]; sb = b[31];
		ea = a[30:23]; eb = b[30:23];
		ma = {(ea != 8'd0), a[22:0]};
		mb = {(eb != 8'd0), b[22:0]};
		swap = {eb, mb} > {ea, ma};
		big_s = swap ? sb : sa;
		big_e = swap ? eb : ea;
		mbig  = swap ? mb : ma;
		msml  = swap ? ma : mb;
		d = (swap ? eb : ea) - (swap ? ea : eb);
		if ((swap ? ea : eb) == 8'd0 && big_e != 8'd0) d = d - 8'd1;
		if (d > 8'd26) begin
			sml_al = '0;
			sticky = (msml != 24'd0);
		end else begin
			sml_al = {msml, 3'b000} >> d;
			sticky = (({msml, 3'b000} & ((27'd1 << d) - 27'd1)) != 27'd0);
		end
		sml_al[0] = sml_al[0] | sticky;
		a_nan = (ea == 8'hFF) && (a[22:0] != 0);
		b_nan = (eb == 8'hFF) && (b[22:0] != 0);
		a_inf = (ea == 8'hFF) && (a[22:0] == 0);
		b_inf = (eb == 8'hFF) && (b[22:0] == 0);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sub_s1   <= sa ^ sb;
			big_s_s1 <= big_s;
			e_s1     <= (big_e == 8'd0) ? 8'd1 : big_e;
			mbig_s1  <= {mbig, 3'b000};
			msml_s1  <= sml_al;
			special_s1 <= a_nan | b_nan | a_inf | b_inf;
			if (a_nan || b_nan || (a_inf && b_inf && (sa != sb)))
				special_v_s1 <= 32'h7FC00000;
			else if (a_inf)
				special_v_s1 <= a;
			else
				special_v_s1 <= b;
		end
	end

	// Stage 2: add, normalize, round.
	logic [27:0] m;
	logic [4:0]  lz;
	logic [9:0]  e;
	logic [27:0] n;
	logic [23:0] mant;
	logic        rnd;
	logic [24:0] mr;
	logic [9:0]  ef;

	always_comb begin
		m = sub_s1 ? ({1'b0, mbig_s1} - {1'b0, msml_s1})
		           : ({1'b0, mbig_s1} + {1'b0, msml_s1});
		// count leading zeros below the carry bit
		lz = 5'd27;
		for (int i = 0; i <= 26; i++) if (m[i]) lz = 5'(26 - i);
		e = {2'b00, e_s1};
		n = m;
		if (m[27]) begin
			n = {1'b0, m[27:2], m[1] | m[0]};
			e = e + 10'd1;
		end else if (m != 28'd0) begin
			if ({5'd0, lz} < e) begin
				n = m << lz;
				e = e - {5'd0, lz};
			end else begin
				n = m << (e - 10'd1);
				e = 10'd0;
			end
		end else begin
			e = 10'd0;
		end
		mant = n[26:3];
		rnd = n[2] && (n[1] || n[0] || n[3]);
		mr = {1'b0, mant} + {24'd0, rnd};
		ef = e;
		if (mr[24]) begin
			mr = mr >> 1;
			ef = ef + 10'd1;
		end else if (ef == 10'd0 && mr[23]) begin
			ef = 10'd1;
		end
		if (special_s1)
			sum = special_v_s1;
		else if (m == 28'd0)
			sum = {(sub_s1 ? 1'b0 : big_s_s1), 31'd0};
		else if (ef >= 10'd255)
			sum = {big_s_s1, 8'hFF, 23'd0};
		else
			sum = {big_s_s1, ef[7:0], mr[22:0]};
	end

endmodule

/* hw/rtl/tcfp_back.sv */
// Back part: executes frame commands against the gain store.
module tcfp_back import tcfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      cmd_take,
	output logic      res_valid,
	output out_beat_t res,
	input  logic      res_take
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ADD  = 3'b010,
		S_OUT  = 3'b100
	} st_t;

	st_t         st_q;
	cmd_t        c_q;
	logic [31:0] g_q [6];
	logic [31:0] sum;
	logic [31:0] bsub;
	logic        busy;

	assign busy = st_q != S_IDLE;
	assign cmd_take = cmd_valid && !busy;
	assign bsub = (cmd.op == OP_SUB) ? {~cmd.payload[31], cmd.payload[30:0]} : cmd.payload;
	assign res_valid = st_q == S_OUT;

	tcfp_fadd u_fadd (
		.clk(clk), .go(cmd_take), .a(g_q[cmd.slot]), .b(bsub), .sum(sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			for (int i = 0; i < 6; i++) g_q[i] <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (cmd_take) begin
						c_q <= cmd;
						res.status      <= cmd.status;
						res.loop_select <= cmd.loop_select;
						res.gain_select <= cmd.gain_select;
						res.gain_value  <= '0;
						if (cmd.status == ST_OK && cmd.op != OP_SET) begin
							st_q <= S_ADD;
						end else begin
							if (cmd.status == ST_OK) begin
								g_q[cmd.slot]  <= cmd.payload;
								res.gain_value <= cmd.payload;
							end
							st_q <= S_OUT;
						end
					end
				end
				S_ADD: begin
					g_q[c_q.slot]  <= sum;
					res.gain_value <= sum;
					st_q <= S_OUT;
				end
				S_OUT: if (res_take) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/tcfp_queue.sv */
// Two-entry command queue between front and back.
module tcfp_queue import tcfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t din,
	output logic full,
	output logic pop_valid,
	output cmd_t dout,
	input  logic pop
);

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) if (push) mem_q[wp_q] <= din;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the tuning command frame parser core.
`timescale 1ns / 1ps

module tb;
	import tcfp_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	tuning_command_frame_parser_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	localparam int FRAME_LIMIT = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	// Beats waiting to be offered, and status beats predicted but not yet seen.
	in_beat_t  pending_beats[$];
	out_beat_t status_due[$];

	// Predicted parser state.
	logic [6:0]  pr_pos;
	logic [7:0]  pr_hdr[5];
	logic [7:0]  pr_pl[4];
	logic [7:0]  pr_prev;
	logic        pr_over;
	logic [31:0] pr_gain[6];

	int errors;
	int beats_in;
	int results_seen;
	int status_hist[4];
	int cycles;
	bit quiet;
	bit hold_on;
	bit hold_done;
	int hold_cnt;
	int tx_gap;
	int rx_gap;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %h, want %h", what, got, want);
		errors++;
	endtask

	// Single-precision add with round to nearest even; a NaN result is canonical.
	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] t32;
		logic        sa, sb, sticky, rnd;
		int          ea, eb, er, d;
		logic [27:0] ma, mb, mr;
		logic [24:0] mn;
		if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
			return CANON_NAN;
		if (a[30:23] == 8'hFF) begin
			if (b[30:23] == 8'hFF && a[31] != b[31])
				return CANON_NAN;
			return a;
		end
		if (b[30:23] == 8'hFF)
			return b;
		// keep the larger magnitude in a
		if (a[30:0] < b[30:0]) begin
			t32 = a;
			a = b;
			b = t32;
		end
		sa = a[31];
		sb = b[31];
		ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
		ma = {1'b0, a[30:23] != 0, a[22:0], 3'b000};
		mb = {1'b0, b[30:23] != 0, b[22:0], 3'b000};
		d = ea - eb;
		if (d >= 27) begin
			mb = {27'd0, mb != 0};
		end else if (d > 0) begin
			sticky = |(mb & ((28'd1 << d) - 28'd1));
			mb = (mb >> d) | {27'd0, sticky};
		end
		mr = (sa == sb) ? ma + mb : ma - mb;
		if (mr == 0)
			return {sa & sb, 31'd0};
		er = ea;
		if (mr[27]) begin
			mr = (mr >> 1) | {27'd0, mr[0]};
			er++;
		end else begin
			while (!mr[26] && er > 1) begin
				mr = mr << 1;
				er--;
			end
		end
		rnd = mr[2] && (mr[1] || mr[0] || mr[3]);
		mn = {1'b0, mr[26:3]} + rnd;
		if (mn[24]) begin
			mn = mn >> 1;
			er++;
		end
		if (er >= 255)
			return {sa, 8'hFF, 23'd0};
		if (!mn[23])
			return {sa, 8'h00, mn[22:0]};
		return {sa, er[7:0], mn[22:0]};
	endfunction

	function automatic void clear_frame_state();
		pr_pos = '0;
		pr_over = 1'b0;
		pr_prev = '0;
		foreach (pr_hdr[i]) pr_hdr[i] = '0;
		foreach (pr_pl[i]) pr_pl[i] = '0;
	endfunction

	// Advance the predicted parser by one accepted beat; queue a status beat at frame end.
	function automatic void predict_beat(input in_beat_t bt);
		out_beat_t   r;
		int          len, lp, gn, slot;
		op_t         op;
		bit          op_ok;
		logic [31:0] pl;
		if (pr_pos >= FRAME_LIMIT)
			pr_over = 1'b1;
		else if (pr_pos < 5)
			pr_hdr[pr_pos] = bt.rx_byte;
		else if (pr_pos < 9)
			pr_pl[pr_pos - 5] = bt.rx_byte;
		if (!bt.frame_end) begin
			pr_prev = bt.rx_byte;
			if (pr_pos < FRAME_LIMIT)
				pr_pos = pr_pos + 7'd1;
			return;
		end
		r = '0;
		r.status = ST_FRAMING;
		len = int'(pr_pos) + 1;
		if (!pr_over && len >= MIN_FRAME && len <= FRAME_LIMIT && pr_hdr[0] == CH_AT
				&& pr_hdr[4] == CH_EQ && pr_prev == CH_BANG && bt.rx_byte == CH_HASH) begin
			case (pr_hdr[1])
				CH_B: lp = 0;
				CH_S: lp = 1;
				CH_T: lp = 2;
				default: lp = -1;
			endcase
			op_ok = 1'b1;
			op = OP_SET;
			case (pr_hdr[2])
				CH_1: op = OP_SET;
				CH_2: op = OP_ADD;
				CH_3: op = OP_SUB;
				default: op_ok = 1'b0;
			endcase
			case (pr_hdr[3])
				CH_P: gn = 0;
				CH_I: gn = 1;
				CH_D: gn = 2;
				default: gn = -1;
			endcase
			r.loop_select = (lp < 0) ? 2'd0 : lp[1:0];
			r.gain_select = (gn < 0) ? 2'd0 : gn[1:0];
			if (lp < 0 || gn < 0 || !op_ok) begin
				r.status = ST_LETTER;
			end else if ((gn == 1 && lp != 1) || (gn == 2 && lp == 1)) begin
				r.status = ST_UNSUP;
			end else begin
				slot = lp * 2 + (gn == 0 ? 0 : 1);
				pl = {pr_pl[3], pr_pl[2], pr_pl[1], pr_pl[0]};
				case (op)
					OP_ADD: pr_gain[slot] = fp_add(pr_gain[slot], pl);
					OP_SUB: pr_gain[slot] = fp_add(pr_gain[slot], {~pl[31], pl[30:0]});
					default: pr_gain[slot] = pl;
				endcase
				r.status = ST_OK;
				r.gain_value = pr_gain[slot];
			end
		end
		status_due.push_back(r);
		clear_frame_state();
	endfunction

	task automatic push_bytes(input logic [7:0] b[$]);
		in_beat_t bt;
		foreach (b[i]) begin
			bt.rx_byte = b[i];
			bt.frame_end = (i == b.size() - 1);
			pending_beats.push_back(bt);
		end
	endtask

	// Build a command frame; pad adds bytes between payload and trailer.
	task automatic push_command(input logic [7:0] lp, input logic [7:0] op, input logic [7:0] gn,
			input logic [31:0] pl, input int pad);
		logic [7:0] b[$];
		b = {CH_AT, lp, op, gn, CH_EQ, pl[7:0], pl[15:8], pl[23:16], pl[31:24]};
		repeat (pad) b.push_back(8'($urandom));
		b.push_back(CH_BANG);
		b.push_back(CH_HASH);
		push_bytes(b);
	endtask

	function automatic logic [31:0] pick_payload();
		case ($urandom_range(0, 13))
			0: return 32'h00000000;
			1: return 32'h80000000;
			2: return 32'h7F800000;
			3: return 32'hFF800000;
			4: return 32'h7FC00001 | ($urandom & 32'h003FFFFF);
			5: return 32'h00000001;
			6: return 32'h807FFFFF;
			7: return 32'h7F7FFFFF;
			8: return 32'h3F800000;
			9: return 32'hBF800000;
			10: return {$urandom_range(0, 1), 8'($urandom_range(100, 150)), 23'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed commands with random content, some broken frames and noise.
	task automatic push_random_frame();
		logic [7:0] loops[3] = '{CH_B, CH_S, CH_T};
		logic [7:0] ops[3]   = '{CH_1, CH_2, CH_3};
		logic [7:0] gains[3] = '{CH_P, CH_I, CH_D};
		logic [7:0] lp, op, gn, b[$];
		int         kind, n;
		lp = loops[$urandom_range(0, 2)];
		op = ops[$urandom_range(0, 2)];
		gn = gains[$urandom_range(0, 2)];
		kind = $urandom_range(0, 19);
		if (kind < 13) begin
			if (gn == CH_I && lp != CH_S && $urandom_range(0, 1))
				lp = CH_S;
			push_command(lp, op, gn, pick_payload(), 0);
		end else if (kind == 13) begin
			case ($urandom_range(0, 2))
				0: lp = 8'($urandom);
				1: op = 8'($urandom);
				default: gn = 8'($urandom);
			endcase
			push_command(lp, op, gn, pick_payload(), 0);
		end else if (kind == 14) begin
			push_command(lp, op, gn, pick_payload(), $urandom_range(1, 60));
		end else if (kind == 15) begin
			n = $urandom_range(1, 10);
			b = {CH_AT, lp, op, gn, CH_EQ, 8'($urandom), 8'($urandom), 8'($urandom), CH_BANG};
			b = b[0:n - 2];
			b.push_back(CH_HASH);
			push_bytes(b);
		end else if (kind == 16) begin
			b = {CH_AT, lp, op, gn, CH_EQ, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), CH_BANG, CH_HASH};
			b[$urandom_range(0, 1) ? 0 : 4] = 8'($urandom);
			if ($urandom_range(0, 1))
				b[$urandom_range(9, 10)] = 8'($urandom);
			push_bytes(b);
		end else begin
			n = $urandom_range(1, 14);
			b = {};
			repeat (n) b.push_back(8'($urandom));
			push_bytes(b);
		end
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0 || in_valid || status_due.size() != 0)
			@(posedge clk);
	endtask

	// Sender: offer the oldest pending beat; hold it while stalled.
	always @(posedge clk) begin
		in_beat_t nxt;
		bit       busy;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_beat(in_data);
				beats_in++;
			end
			busy = in_valid && in_stall;
			if (!busy) begin
				if (!quiet && tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 11) == 0) begin
					tx_gap = $urandom_range(1, 18) - 1;
					in_valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					nxt = pending_beats.pop_front();
					in_valid <= 1'b1;
					in_data <= nxt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, once, while the sender keeps going.
	always @(posedge clk) begin
		if (arst_n && !hold_done && beats_in >= 200) begin
			if (hold_cnt == HOLD_CYCLES) begin
				hold_done <= 1'b1;
				hold_on <= 1'b0;
			end else begin
				hold_cnt <= hold_cnt + 1;
				hold_on <= 1'b1;
			end
		end
	end

	// Receiver: check each accepted status beat against the oldest prediction.
	always @(posedge clk) begin
		out_beat_t want;
		bit        stall_next;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (status_due.size() == 0) begin
					report("unexpected beat", 32'(out_data.status), 32'hFFFFFFFF);
				end else begin
					want = status_due.pop_front();
					status_hist[want.status]++;
					if (out_data.status != want.status)
						report("status", 32'(out_data.status), 32'(want.status));
					if (out_data.loop_select != want.loop_select)
						report("loop_select", 32'(out_data.loop_select), 32'(want.loop_select));
					if (out_data.gain_select != want.gain_select)
						report("gain_select", 32'(out_data.gain_select), 32'(want.gain_select));
					if (out_data.gain_value != want.gain_value)
						report("gain_value", out_data.gain_value, want.gain_value);
				end
			end
			stall_next = hold_on;
			if (!quiet && rx_gap > 0) begin
				rx_gap--;
				stall_next = 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				rx_gap = $urandom_range(1, 18) - 1;
				stall_next = 1'b1;
			end
			out_stall <= stall_next;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [7:0] b[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		errors = 0;
		beats_in = 0;
		results_seen = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_on = 1'b0;
		hold_done = 1'b0;
		hold_cnt = 0;
		tx_gap = 0;
		rx_gap = 0;
		foreach (status_hist[i]) status_hist[i] = 0;
		clear_frame_state();
		foreach (pr_gain[i]) pr_gain[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: every slot and operation, float extremes, and each rejection.
		// The long receiver hold-off lands in this part.
		push_command(CH_B, CH_1, CH_P, 32'h3F800000, 0);
		push_command(CH_B, CH_2, CH_P, 32'h3F800000, 0);
		push_command(CH_B, CH_3, CH_P, 32'h40000000, 0);
		push_command(CH_B, CH_1, CH_D, 32'h7F7FFFFF, 0);
		push_command(CH_B, CH_2, CH_D, 32'h7F7FFFFF, 0);
		push_command(CH_S, CH_1, CH_P, 32'h7FA00000, 0);
		push_command(CH_S, CH_2, CH_P, 32'h3F800000, 0);
		push_command(CH_S, CH_1, CH_I, 32'h7F800000, 0);
		push_command(CH_S, CH_3, CH_I, 32'h7F800000, 0);
		push_command(CH_T, CH_1, CH_P, 32'h00000001, 0);
		push_command(CH_T, CH_3, CH_P, 32'h00800000, 0);
		push_command(CH_T, CH_2, CH_D, 32'hFFFFFFFF, 0);
		push_command(CH_T, CH_1, CH_I, 32'h3F800000, 0);
		push_command(CH_S, CH_1, CH_D, 32'h3F800000, 0);
		push_command(8'h58, CH_1, CH_P, 32'h3F800000, 0);
		push_command(CH_B, 8'h34, CH_D, 32'h3F800000, 0);
		push_command(CH_S, CH_2, 8'hFF, 32'h3F800000, 0);
		push_command(CH_B, CH_1, CH_P, 32'h00000000, 53);
		push_command(CH_B, CH_1, CH_P, 32'h00000000, 54);
		push_command(CH_T, CH_1, CH_D, 32'h00000000, 70);
		b = {CH_AT, CH_B, CH_1, CH_P, CH_EQ, CH_BANG, CH_HASH};
		push_bytes(b);
		b = {8'h00, CH_B, CH_1, CH_P, CH_EQ, 8'h00, 8'h00, 8'h00, 8'h00, CH_BANG, CH_HASH};
		push_bytes(b);
		b = {CH_AT, CH_B, CH_1, CH_P, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, CH_BANG, CH_HASH};
		push_bytes(b);
		b = {CH_AT, CH_B, CH_1, CH_P, CH_EQ, 8'h00, 8'h00, 8'h00, 8'h00, CH_HASH, CH_BANG};
		push_bytes(b);
		b = {8'hFF};
		push_bytes(b);
		wait_drained();

		// Random, first part.
		while (pending_beats.size() < 70)
			push_random_frame();
		// Pause the sender until every status beat has come back.
		wait_drained();

		// Random, last part: no idling on either side.
		quiet = 1'b1;
		while (pending_beats.size() < 50)
			push_random_frame();
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Covered %0d beats, %0d status beats", beats_in, results_seen);
		$display("  (ok %0d, framing %0d, letter %0d, unsupported %0d), mismatches %0d",
			status_hist[0], status_hist[1], status_hist[2], status_hist[3], errors);
		if (errors == 0 && status_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
